// ===== hdl/unsigned_decimal_format_macros.svh =====
// Assertion macros for the file that checks this block.
`ifndef UNSIGNED_DECIMAL_FORMAT_MACROS_SVH
`define UNSIGNED_DECIMAL_FORMAT_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define UDF_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at every rising clock edge outside reset.
`define UDF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/udf_pkg.sv =====
`timescale 1ns / 1ps

package udf_pkg;

    localparam int PREC_W = 7;
    localparam int CHAR_W = 8;
    localparam int BCD_W  = 4;

    localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] ASCII_NINE  = 8'h39;
    localparam logic [BCD_W-1:0]  DABBLE_MIN  = 4'd5;
    localparam logic [BCD_W-1:0]  DABBLE_ADD  = 4'd3;

    typedef enum logic [1:0] {
        FS_IDLE,
        FS_CONV,
        FS_PUSH
    } t_front_state;

endpackage

// ===== hdl/udf_queue.sv =====
`timescale 1ns / 1ps

module udf_queue
    import udf_pkg::*;
#(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_wdata,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_rdata,
    output logic             o_empty
);

    logic [WIDTH-1:0] r_mem [2];
    logic             r_wp;
    logic             r_rp;
    logic [1:0]       r_count;
    logic             w_do_push;
    logic             w_do_pop;

    assign o_full    = (r_count == 2'd2);
    assign o_empty   = (r_count == 2'd0);
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;
    assign o_rdata   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= 1'b0;
            r_rp    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (w_do_push) begin
                r_wp <= ~r_wp;
            end
            if (w_do_pop) begin
                r_rp <= ~r_rp;
            end
            unique case ({w_do_push, w_do_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wp] <= i_wdata;
        end
    end

endmodule

// ===== hdl/udf_front.sv =====
`timescale 1ns / 1ps

module udf_front
    import udf_pkg::*;
#(
    parameter int VALUE_BITS    = 32,
    parameter int MAX_PRECISION = 63,
    parameter int NDIG          = 10,
    parameter int CNT_W         = 6
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic [VALUE_BITS-1:0]    i_value,
    input  logic signed [PREC_W-1:0] i_precision,
    output logic                     o_push,
    input  logic                     i_full,
    output logic [NDIG*BCD_W-1:0]    o_bcd,
    output logic [CNT_W-1:0]         o_total,
    output logic                     o_empty_res
);

    localparam int STEP_W = $clog2(VALUE_BITS + 1);

    t_front_state              r_state;
    t_front_state              n_state;
    logic [VALUE_BITS-1:0]     r_bin;
    logic [NDIG*BCD_W-1:0]     r_bcd;
    logic [NDIG*BCD_W-1:0]     w_adj;
    logic [STEP_W-1:0]         r_step;
    logic                      r_has_prec;
    logic [CNT_W-1:0]          r_prec;
    logic [CNT_W-1:0]          w_ndig;
    logic [CNT_W-1:0]          w_ndig_eff;
    logic                      w_accept;

    assign w_accept = i_valid && o_ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            FS_IDLE: if (i_valid) n_state = FS_CONV;
            FS_CONV: if (r_step == STEP_W'(1)) n_state = FS_PUSH;
            FS_PUSH: if (!i_full) n_state = FS_IDLE;
            default: n_state = FS_IDLE;
        endcase
    end

    always_comb begin
        o_ready = 1'b0;
        o_push  = 1'b0;
        unique case (r_state)
            FS_IDLE: o_ready = 1'b1;
            FS_PUSH: o_push  = 1'b1;
            default: begin
                o_ready = 1'b0;
                o_push  = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= FS_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Each BCD digit of five or more gets three added before the shift.
    always_comb begin
        for (int i = 0; i < NDIG; i++) begin
            if (r_bcd[i*BCD_W +: BCD_W] >= DABBLE_MIN) begin
                w_adj[i*BCD_W +: BCD_W] = r_bcd[i*BCD_W +: BCD_W] + DABBLE_ADD;
            end else begin
                w_adj[i*BCD_W +: BCD_W] = r_bcd[i*BCD_W +: BCD_W];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_bin      <= i_value;
            r_bcd      <= '0;
            r_step     <= STEP_W'(VALUE_BITS);
            r_has_prec <= !i_precision[PREC_W-1];
            if (int'(i_precision[PREC_W-2:0]) > MAX_PRECISION) begin
                r_prec <= CNT_W'(MAX_PRECISION);
            end else begin
                r_prec <= CNT_W'(i_precision[PREC_W-2:0]);
            end
        end else if (r_state == FS_CONV) begin
            r_bcd  <= {w_adj[NDIG*BCD_W-2:0], r_bin[VALUE_BITS-1]};
            r_bin  <= {r_bin[VALUE_BITS-2:0], 1'b0};
            r_step <= r_step - STEP_W'(1);
        end
    end

    always_comb begin
        w_ndig = '0;
        for (int i = 0; i < NDIG; i++) begin
            if (r_bcd[i*BCD_W +: BCD_W] != '0) begin
                w_ndig = CNT_W'(i + 1);
            end
        end
    end

    // A zero value still prints one digit unless the precision is exactly zero.
    assign w_ndig_eff = (w_ndig == '0 && !(r_has_prec && r_prec == '0)) ?
                        CNT_W'(1) : w_ndig;
    assign o_total     = (r_has_prec && r_prec > w_ndig_eff) ? r_prec : w_ndig_eff;
    assign o_empty_res = (o_total == '0);
    assign o_bcd       = r_bcd;

endmodule

// ===== hdl/udf_back.sv =====
`timescale 1ns / 1ps

module udf_back
    import udf_pkg::*;
#(
    parameter int NDIG  = 10,
    parameter int CNT_W = 6
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_q_empty,
    input  logic [NDIG*BCD_W-1:0] i_bcd,
    input  logic [CNT_W-1:0]      i_total,
    input  logic                  i_empty_res,
    output logic                  o_pop,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [CHAR_W-1:0]     o_char_code,
    output logic                  o_last,
    output logic                  o_empty_res
);

    localparam int IDX_W = (NDIG > 1) ? $clog2(NDIG) : 1;

    logic                  r_active;
    logic                  r_empty;
    logic [CNT_W-1:0]      r_pos;
    logic [NDIG*BCD_W-1:0] r_bcd;
    logic                  r_ovalid;
    logic [CHAR_W-1:0]     r_ochar;
    logic                  r_olast;
    logic                  r_oempty;
    logic                  w_load;
    logic                  w_adv;
    logic                  w_final;
    logic [BCD_W-1:0]      w_digit;
    logic [IDX_W-1:0]      w_idx;

    assign w_load  = !r_active && !i_q_empty;
    assign o_pop   = w_load;
    assign w_adv   = r_active && (!r_ovalid || i_ready);
    assign w_final = r_empty || (r_pos == '0);
    assign w_idx   = r_pos[IDX_W-1:0];

    // Positions above the top BCD digit are leading zero padding.
    always_comb begin
        if (r_pos < CNT_W'(NDIG)) begin
            w_digit = r_bcd[{w_idx, 2'b00} +: BCD_W];
        end else begin
            w_digit = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (w_load) begin
                r_active <= 1'b1;
            end else if (w_adv && w_final) begin
                r_active <= 1'b0;
            end
            if (w_adv) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_bcd   <= i_bcd;
            r_pos   <= i_total - CNT_W'(1);
            r_empty <= i_empty_res;
        end else if (w_adv) begin
            r_pos <= r_pos - CNT_W'(1);
        end
        if (w_adv) begin
            r_ochar  <= r_empty ? '0 : (ASCII_ZERO + {{(CHAR_W-BCD_W){1'b0}}, w_digit});
            r_olast  <= w_final;
            r_oempty <= r_empty;
        end
    end

    assign o_valid     = r_ovalid;
    assign o_char_code = r_ochar;
    assign o_last      = r_olast;
    assign o_empty_res = r_oempty;

endmodule

// ===== hdl/unsigned_decimal_format.sv =====
`timescale 1ns / 1ps

// Formats an unsigned number as decimal ASCII digits, most significant first, padded on
// the left with '0' up to the given precision (negative precision means none, larger
// precision saturates at MAX_PRECISION). Value 0 with precision 0 gives a single item
// flagged empty in tuser. The front takes a new input item only once it has converted the
// last one and pushed it, through the double-dabble converter that shifts one value bit per
// cycle; a two-entry queue hands the digits to the back, which loads each entry and then
// sends one character per cycle while the output is ready.
`include "unsigned_decimal_format_macros.svh"

module unsigned_decimal_format
    import udf_pkg::*;
#(
    parameter int MAX_PRECISION = 63,
    parameter int VALUE_BITS    = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    // value, then precision, then zero fill
    input  logic [((VALUE_BITS+PREC_W+7)/8)*8-1:0] i_s_axis_tdata,
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    // char_code
    output logic [CHAR_W-1:0]    o_m_axis_tdata,
    output logic                 o_m_axis_tlast,
    // empty_res
    output logic                 o_m_axis_tuser
);

    localparam int NDIG   = (VALUE_BITS * 30103) / 100000 + 1;
    localparam int CNT_MAX = (MAX_PRECISION > NDIG) ? MAX_PRECISION : NDIG;
    localparam int CNT_W  = $clog2(CNT_MAX + 1);
    localparam int ENT_W  = NDIG * BCD_W + CNT_W + 1;

    logic                  w_push;
    logic                  w_full;
    logic                  w_q_empty;
    logic                  w_pop;
    logic [NDIG*BCD_W-1:0] w_f_bcd;
    logic [CNT_W-1:0]      w_f_total;
    logic                  w_f_empty;
    logic [ENT_W-1:0]      w_rdata;

    udf_front #(
        .VALUE_BITS    (VALUE_BITS),
        .MAX_PRECISION (MAX_PRECISION),
        .NDIG          (NDIG),
        .CNT_W         (CNT_W)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_axis_tvalid),
        .o_ready     (o_s_axis_tready),
        .i_value     (i_s_axis_tdata[VALUE_BITS-1:0]),
        .i_precision (i_s_axis_tdata[VALUE_BITS+PREC_W-1:VALUE_BITS]),
        .o_push      (w_push),
        .i_full      (w_full),
        .o_bcd       (w_f_bcd),
        .o_total     (w_f_total),
        .o_empty_res (w_f_empty)
    );

    udf_queue #(
        .WIDTH (ENT_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_wdata ({w_f_empty, w_f_total, w_f_bcd}),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_rdata (w_rdata),
        .o_empty (w_q_empty)
    );

    udf_back #(
        .NDIG  (NDIG),
        .CNT_W (CNT_W)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (w_q_empty),
        .i_bcd       (w_rdata[NDIG*BCD_W-1:0]),
        .i_total     (w_rdata[NDIG*BCD_W +: CNT_W]),
        .i_empty_res (w_rdata[ENT_W-1]),
        .o_pop       (w_pop),
        .o_valid     (o_m_axis_tvalid),
        .i_ready     (i_m_axis_tready),
        .o_char_code (o_m_axis_tdata),
        .o_last      (o_m_axis_tlast),
        .o_empty_res (o_m_axis_tuser)
    );

    `UDF_ASSERT_NOW(a_empty_is_last, o_m_axis_tvalid && o_m_axis_tuser, o_m_axis_tlast, "empty item without tlast")
    `UDF_ASSERT_NOW(a_empty_no_char, o_m_axis_tvalid && o_m_axis_tuser, o_m_axis_tdata == '0, "empty item carries a character")
    `UDF_ASSERT_NOW(a_char_is_digit, o_m_axis_tvalid && !o_m_axis_tuser, (o_m_axis_tdata >= ASCII_ZERO) && (o_m_axis_tdata <= ASCII_NINE), "character is not a decimal digit")
    `UDF_ASSERT_NEXT(a_push_leaves, w_push && !w_full, o_s_axis_tready, "front did not return to idle after enqueue")

endmodule
